FILE: rtl/msdq_pkg.sv
// Shared constants and codes of the multi-socket datagram queue.
package msdq_pkg;

    localparam int SOCKETS_DEF    = 8;
    localparam int RING_DEPTH_DEF = 8;
    localparam int SLOT_BYTES_DEF = 2048;

    localparam int OP_W   = 2;
    localparam int ID_W   = 3;
    localparam int ADDR_W = 32;
    localparam int BYTE_W = 8;
    localparam int MAXB_W = 16;
    localparam int ST_W   = 2;
    localparam int LEN_W  = 12;
    localparam int DROP_W = 32;

    localparam logic [OP_W-1:0] OP_OPEN    = 2'd0;
    localparam logic [OP_W-1:0] OP_CLOSE   = 2'd1;
    localparam logic [OP_W-1:0] OP_DELIVER = 2'd2;
    localparam logic [OP_W-1:0] OP_READ    = 2'd3;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD    = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [ST_W-1:0] ST_NOFREE = 2'd3;

endpackage

FILE: rtl/msdq_if.sv
// Request and response channel interfaces of the datagram queue.
interface msdq_in_if;
    logic                          valid;
    logic                          ready;
    logic [msdq_pkg::OP_W-1:0]     op;
    logic [msdq_pkg::ID_W-1:0]     sock_id;
    logic [msdq_pkg::ADDR_W-1:0]   src_addr;
    logic [msdq_pkg::BYTE_W-1:0]   data_byte;
    logic                          last;
    logic [msdq_pkg::MAXB_W-1:0]   max_bytes;

    modport source (output valid, op, sock_id, src_addr, data_byte, last, max_bytes,
                    input ready);
    modport sink (input valid, op, sock_id, src_addr, data_byte, last, max_bytes,
                  output ready);
endinterface

interface msdq_out_if;
    logic                          valid;
    logic                          ready;
    logic [msdq_pkg::ST_W-1:0]     status;
    logic [msdq_pkg::ID_W-1:0]     sock_out;
    logic [msdq_pkg::BYTE_W-1:0]   byte_out;
    logic [msdq_pkg::ADDR_W-1:0]   src_out;
    logic [msdq_pkg::LEN_W-1:0]    msg_len;
    logic                          last_out;
    logic [msdq_pkg::DROP_W-1:0]   drops_out;

    modport source (output valid, status, sock_out, byte_out, src_out, msg_len, last_out,
                    drops_out, input ready);
    modport sink (input valid, status, sock_out, byte_out, src_out, msg_len, last_out,
                  drops_out, output ready);
endinterface

FILE: rtl/msdq_bank.sv
// Payload and slot descriptor memories of one socket's ring.
module msdq_bank #(
    parameter int RING_DEPTH = msdq_pkg::RING_DEPTH_DEF,
    parameter int SLOT_BYTES = msdq_pkg::SLOT_BYTES_DEF,
    parameter int RW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
    parameter int OW = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1,
    parameter int PW = $clog2(SLOT_BYTES + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_pwe,
    input  logic [RW-1:0]                 i_pw_slot,
    input  logic [OW-1:0]                 i_pw_off,
    input  logic [msdq_pkg::BYTE_W-1:0]   i_pw_data,
    input  logic                          i_mwe,
    input  logic [RW-1:0]                 i_mw_slot,
    input  logic [PW-1:0]                 i_mw_len,
    input  logic [msdq_pkg::ADDR_W-1:0]   i_mw_src,
    input  logic                          i_mre,
    input  logic [RW-1:0]                 i_mr_slot,
    output logic [PW-1:0]                 o_mr_len,
    output logic [msdq_pkg::ADDR_W-1:0]   o_mr_src,
    input  logic                          i_pre,
    input  logic [RW-1:0]                 i_pr_slot,
    input  logic [OW-1:0]                 i_pr_off,
    output logic [msdq_pkg::BYTE_W-1:0]   o_pr_data
);
    import msdq_pkg::*;

    localparam int PDEPTH = RING_DEPTH * (2 ** OW);

    logic [BYTE_W-1:0] r_payload [PDEPTH];
    logic [PW-1:0]     r_len     [RING_DEPTH];
    logic [ADDR_W-1:0] r_src     [RING_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_pwe) begin
            r_payload[{i_pw_slot, i_pw_off}] <= i_pw_data;
        end
        if (i_pre) begin
            o_pr_data <= r_payload[{i_pr_slot, i_pr_off}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_mwe) begin
            r_len[i_mw_slot] <= i_mw_len;
            r_src[i_mw_slot] <= i_mw_src;
        end
        if (i_mre) begin
            o_mr_len <= r_len[i_mr_slot];
            o_mr_src <= r_src[i_mr_slot];
        end
    end

endmodule

FILE: rtl/multi_socket_datagram_queue.sv
// Multi-socket datagram queue: socket table, control sequencer and per-socket rings.
//
// Requests arrive as words on i_req and responses leave on o_rsp, both valid/ready.
// Open, close and read give one response word each; a delivered byte gives none.
// Open, close and deliver finish in the cycle they are accepted, so these words
// can follow each other every cycle while the response register is free.
// A read that finds a datagram reads the descriptor memory of the socket when it
// is accepted, the payload memory in S_META, and registers the result in S_DATA
// once the response register is free. Reads of a bad, closed or empty socket
// answer in the accept cycle.
// Each socket owns its own payload bank, so a delivered byte that fits in the slot
// is written to every open socket with room at once.
// After reset all sockets are closed and all counters are zero; no clearing pass
// is needed because ring contents are only read after being written.
// When the receiver holds ready low, the response stays in the output register
// and no new request is accepted until it has been taken.
module multi_socket_datagram_queue #(
    parameter int SOCKETS    = msdq_pkg::SOCKETS_DEF,
    parameter int RING_DEPTH = msdq_pkg::RING_DEPTH_DEF,
    parameter int SLOT_BYTES = msdq_pkg::SLOT_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    msdq_in_if.sink     i_req,
    msdq_out_if.source  o_rsp
);
    import msdq_pkg::*;

    localparam int SW = (SOCKETS > 1) ? $clog2(SOCKETS) : 1;
    localparam int RW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int OW = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
    localparam int PW = $clog2(SLOT_BYTES + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_META = 2'd1;
    localparam logic [1:0] S_DATA = 2'd2;

    logic [1:0]        r_state;
    logic [SOCKETS-1:0] r_used;
    logic [RW-1:0]     r_head  [SOCKETS];
    logic [CW-1:0]     r_count [SOCKETS];
    logic [DROP_W-1:0] r_drops [SOCKETS];
    logic [PW-1:0]     r_dpos;
    logic [PW-1:0]     r_rpos;
    logic [SW-1:0]     r_id;
    logic [MAXB_W-1:0] r_maxb;
    logic [MAXB_W-1:0] r_n;
    logic [PW-1:0]     r_pos;

    logic              r_ov;
    logic [ST_W-1:0]   r_status;
    logic [ID_W-1:0]   r_sock_out;
    logic [BYTE_W-1:0] r_byte;
    logic [ADDR_W-1:0] r_src;
    logic [LEN_W-1:0]  r_len;
    logic              r_last;
    logic [DROP_W-1:0] r_drops_out;

    logic [RW-1:0]     w_tail   [SOCKETS];
    logic [SOCKETS-1:0] w_room;
    logic [SOCKETS-1:0] w_pwe;
    logic [SOCKETS-1:0] w_mwe;
    logic [SOCKETS-1:0] w_mre;
    logic [SOCKETS-1:0] w_pre;
    logic [PW-1:0]     w_mr_len [SOCKETS];
    logic [ADDR_W-1:0] w_mr_src [SOCKETS];
    logic [BYTE_W-1:0] w_pr_data [SOCKETS];

    logic              w_acc;
    logic              w_out_free;
    logic              w_id_ok;
    logic [SW-1:0]     w_sid;
    logic              w_fits;
    logic [PW-1:0]     n_dpos;
    logic              w_any_free;
    logic [SW-1:0]     w_free;
    logic [MAXB_W-1:0] w_len16;
    logic [MAXB_W-1:0] w_n;
    logic [PW-1:0]     w_pos;
    logic              w_pop;
    logic [PW:0]       w_pos_inc;

    assign w_out_free  = !r_ov || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && w_out_free;
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_sid       = SW'(i_req.sock_id);
    assign w_id_ok     = (int'(i_req.sock_id) < SOCKETS);
    assign w_fits      = (int'(r_dpos) < SLOT_BYTES);
    assign n_dpos      = w_fits ? r_dpos + PW'(1) : r_dpos;

    always_comb begin
        w_any_free = 1'b0;
        w_free     = '0;
        for (int s = SOCKETS - 1; s >= 0; s--) begin
            if (!r_used[s]) begin
                w_any_free = 1'b1;
                w_free     = SW'(s);
            end
        end
    end

    always_comb begin
        logic [CW:0] t;
        for (int s = 0; s < SOCKETS; s++) begin
            t = (CW + 1)'(r_head[s]) + (CW + 1)'(r_count[s]);
            if (int'(t) >= RING_DEPTH) begin
                t = t - (CW + 1)'(RING_DEPTH);
            end
            w_tail[s] = RW'(t);
            w_room[s] = int'(r_count[s]) < RING_DEPTH;
            w_pwe[s]  = w_acc && (i_req.op == OP_DELIVER) && r_used[s] && w_room[s] && w_fits;
            w_mwe[s]  = w_acc && (i_req.op == OP_DELIVER) && i_req.last && r_used[s]
                        && w_room[s];
            w_mre[s]  = w_acc && (i_req.op == OP_READ) && (w_sid == SW'(s));
            w_pre[s]  = (r_state == S_META) && (r_id == SW'(s));
        end
    end

    assign w_len16   = MAXB_W'(w_mr_len[r_id]);
    assign w_n       = (w_len16 > r_maxb) ? r_maxb : w_len16;
    assign w_pos     = (MAXB_W'(r_rpos) >= w_n) ? PW'(w_n - MAXB_W'(1)) : r_rpos;
    assign w_pos_inc = (PW + 1)'(r_pos) + (PW + 1)'(1);
    assign w_pop     = (r_n == '0) || (MAXB_W'(w_pos_inc) >= r_n);

    for (genvar g = 0; g < SOCKETS; g++) begin : g_bank
        msdq_bank #(
            .RING_DEPTH (RING_DEPTH),
            .SLOT_BYTES (SLOT_BYTES),
            .RW         (RW),
            .OW         (OW),
            .PW         (PW)
        ) u_bank (
            .i_clk      (i_clk),
            .i_pwe      (w_pwe[g]),
            .i_pw_slot  (w_tail[g]),
            .i_pw_off   (OW'(r_dpos)),
            .i_pw_data  (i_req.data_byte),
            .i_mwe      (w_mwe[g]),
            .i_mw_slot  (w_tail[g]),
            .i_mw_len   (n_dpos),
            .i_mw_src   (i_req.src_addr),
            .i_mre      (w_mre[g]),
            .i_mr_slot  (r_head[g]),
            .o_mr_len   (w_mr_len[g]),
            .o_mr_src   (w_mr_src[g]),
            .i_pre      (w_pre[g]),
            .i_pr_slot  (r_head[g]),
            .i_pr_off   (OW'(w_pos)),
            .o_pr_data  (w_pr_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_dpos  <= '0;
            r_rpos  <= '0;
            r_ov    <= 1'b0;
            for (int s = 0; s < SOCKETS; s++) begin
                r_head[s]  <= '0;
                r_count[s] <= '0;
                r_drops[s] <= '0;
            end
        end else begin
            if (r_ov && o_rsp.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_status    <= ST_OK;
                        r_sock_out  <= '0;
                        r_byte      <= '0;
                        r_src       <= '0;
                        r_len       <= '0;
                        r_last      <= 1'b0;
                        r_drops_out <= '0;
                        case (i_req.op)
                            OP_OPEN: begin
                                r_ov <= 1'b1;
                                if (w_any_free) begin
                                    r_used[w_free]  <= 1'b1;
                                    r_head[w_free]  <= '0;
                                    r_count[w_free] <= '0;
                                    r_drops[w_free] <= '0;
                                    r_sock_out      <= ID_W'(w_free);
                                end else begin
                                    r_status <= ST_NOFREE;
                                end
                            end
                            OP_CLOSE: begin
                                r_ov <= 1'b1;
                                if (w_id_ok) begin
                                    r_used[w_sid] <= 1'b0;
                                end else begin
                                    r_status <= ST_BAD;
                                end
                            end
                            OP_DELIVER: begin
                                r_dpos <= i_req.last ? '0 : n_dpos;
                                if (i_req.last) begin
                                    for (int s = 0; s < SOCKETS; s++) begin
                                        if (r_used[s]) begin
                                            if (w_room[s]) begin
                                                r_count[s] <= r_count[s] + CW'(1);
                                            end else begin
                                                r_drops[s] <= r_drops[s] + DROP_W'(1);
                                            end
                                        end
                                    end
                                end
                            end
                            default: begin
                                r_id   <= w_sid;
                                r_maxb <= i_req.max_bytes;
                                if (!w_id_ok || !r_used[w_sid]) begin
                                    r_ov     <= 1'b1;
                                    r_status <= ST_BAD;
                                end else if (r_count[w_sid] == '0) begin
                                    r_ov        <= 1'b1;
                                    r_status    <= ST_EMPTY;
                                    r_drops_out <= r_drops[w_sid];
                                end else begin
                                    r_state <= S_META;
                                end
                            end
                        endcase
                    end
                end
                S_META: begin
                    r_n     <= w_n;
                    r_pos   <= w_pos;
                    r_state <= S_DATA;
                end
                S_DATA: begin
                    if (w_out_free) begin
                        r_ov        <= 1'b1;
                        r_status    <= ST_OK;
                        r_sock_out  <= '0;
                        r_src       <= w_mr_src[r_id];
                        r_len       <= LEN_W'(r_n);
                        r_byte      <= (r_n == '0) ? '0 : w_pr_data[r_id];
                        r_last      <= w_pop;
                        r_drops_out <= r_drops[r_id];
                        if (w_pop) begin
                            r_rpos <= '0;
                            r_count[r_id] <= r_count[r_id] - CW'(1);
                            if (int'(r_head[r_id]) == RING_DEPTH - 1) begin
                                r_head[r_id] <= '0;
                            end else begin
                                r_head[r_id] <= r_head[r_id] + RW'(1);
                            end
                        end else begin
                            r_rpos <= PW'(w_pos_inc);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid     = r_ov;
    assign o_rsp.status    = r_status;
    assign o_rsp.sock_out  = r_sock_out;
    assign o_rsp.byte_out  = r_byte;
    assign o_rsp.src_out   = r_src;
    assign o_rsp.msg_len   = r_len;
    assign o_rsp.last_out  = r_last;
    assign o_rsp.drops_out = r_drops_out;

    // The descriptor read is always followed by the payload read.
    a_meta_then_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_META) |=> (r_state == S_DATA))
        else $error("payload read did not follow descriptor read");

    // The deliver position never passes the slot size.
    a_dpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_dpos) <= SLOT_BYTES)
        else $error("deliver position out of range");

    // A new response comes only from an accepted word or a finished read.
    a_rsp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !$past(r_ov)) |-> ($past(w_acc) || $past(r_state == S_DATA)))
        else $error("response without a cause");

endmodule
